// ----- sv/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared codes and controller/datapath interface types for the tap tempo
// beat generator.
// ----------------------------------------------------------------------------
package ttb_pkg;

	// Command codes on the input word
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_TAP    = 2'd1;
	localparam logic [1:0] CMD_SUBDIV = 2'd2;

	localparam int unsigned DIV_W = 7;   // width of divisor / subdivision
	localparam int unsigned TAP_W = 2;   // width of the interval counter

	// Intervals per measurement; the average is a fixed shift by two
	localparam int unsigned TAP_INTERVALS = 4;

	// Last interval index before the average is taken
	localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_INTERVALS - 1);

	// Controller -> datapath
	typedef struct packed {
		logic take;     // apply the input word, load result
		logic div_go;   // start period / subdivision division
	} ttb_ctrl_t;

	// Datapath -> controller
	typedef struct packed {
		logic needs_div;  // input word will change the beat period
		logic div_done;   // quotient is being written this cycle
		logic div_busy;   // divider is iterating
	} ttb_stat_t;

endpackage

// ----- sv/tap_tempo_beat_generator_top.sv -----
// ----------------------------------------------------------------------------
// tap_tempo_beat_generator_top
// Tap tempo beat generator: learns a period from four tap intervals and
// emits beats at period/subdivision along with an LED toggling every period.
// ----------------------------------------------------------------------------
// Each input word (tick, tap or subdivision) yields one result word in the cycle
// after it is accepted, and ticks and ordinary taps can be taken every cycle
// while the output side keeps up. A word that changes the beat period (the
// tap that completes a measurement, a subdivision change, or a learn timeout
// tick) starts a restoring divider that produces one quotient bit per cycle;
// input stays not-ready after such a word until the divider has finished. The
// result of that word is delivered without waiting for the division.
module tap_tempo_beat_generator_top import ttb_pkg::*; #(
	parameter int unsigned COUNT_WIDTH   = 32,
	parameter int unsigned MAX_DIVISOR   = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [DIV_W-1:0]       divisor,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   beat,
	output logic                   led_level,
	output logic                   learning,
	output logic [TAP_W-1:0]       taps_taken,
	output logic [COUNT_WIDTH-1:0] tempo_period
);

	ttb_ctrl_t ctrl;
	ttb_stat_t stat;

	ttb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	ttb_datapath #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.MAX_DIVISOR (MAX_DIVISOR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.command      (command),
		.divisor      (divisor),
		.beat         (beat),
		.led_level    (led_level),
		.learning     (learning),
		.taps_taken   (taps_taken),
		.tempo_period (tempo_period)
	);

	// interval count only runs during learning
	a_taps_in_learn: assert property (@(posedge clk) disable iff (!arst_n)
		(taps_taken != '0) |-> learning)
		else $error("taps_taken nonzero outside learn mode");

	// no word taken while the divider is still producing the beat period
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_busy |-> !in_ready)
		else $error("input ready during division");

	// every accepted word produces a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted word without result");

endmodule

// ----- sv/ttb_divider.sv -----
// ----------------------------------------------------------------------------
// ttb_divider
// Restoring serial divider, one quotient bit per cycle. Divides a count by
// the small subdivision value.
// ----------------------------------------------------------------------------
module ttb_divider import ttb_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH-1:0] dividend,
	input  logic [DIV_W-1:0]       divisor,
	output logic                   busy,
	output logic                   done,
	output logic [COUNT_WIDTH-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(COUNT_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [COUNT_WIDTH-1:0] quo_q;
	logic [DIV_W-1:0]       rem_q;
	logic [DIV_W-1:0]       dvs_q;

	logic [DIV_W:0]         rem_sh;
	logic                   ge;
	logic [DIV_W:0]         rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quo_q[COUNT_WIDTH-1]};
		ge      = (rem_sh >= {1'b0, dvs_q});
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COUNT_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[COUNT_WIDTH-2:0], ge};
			rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/ttb_datapath.sv -----
// ----------------------------------------------------------------------------
// ttb_datapath
// Tempo state: beat and LED timers, tap interval accumulation, learned
// period and subdivision, plus the serial divider for the beat period.
// ----------------------------------------------------------------------------
module ttb_datapath import ttb_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned MAX_DIVISOR = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ttb_ctrl_t              ctrl,
	output ttb_stat_t              stat,
	input  logic [1:0]             command,
	input  logic [DIV_W-1:0]       divisor,
	output logic                   beat,
	output logic                   led_level,
	output logic                   learning,
	output logic [TAP_W-1:0]       taps_taken,
	output logic [COUNT_WIDTH-1:0] tempo_period
);

	localparam int unsigned CW = COUNT_WIDTH;
	localparam int unsigned SUM_W = CW + 2;
	localparam logic [DIV_W-1:0] MAX_DIV_SAT =
		(MAX_DIVISOR > (2**DIV_W - 1)) ? DIV_W'(2**DIV_W - 1) : DIV_W'(MAX_DIVISOR);
	localparam logic [CW-1:0] FULL = '1;

	logic             learn_q, n_learn;
	logic [TAP_W-1:0] tap_q, n_tap;
	logic [SUM_W-1:0] sum_q, n_sum;
	logic [CW-1:0]    bcnt_q, n_bcnt;
	logic [CW-1:0]    bper_q, n_bper;
	logic [CW-1:0]    lcnt_q, n_lcnt;
	logic             lrun_q, n_lrun;
	logic             led_q, n_led;
	logic [CW-1:0]    lper_q, n_lper;
	logic [DIV_W-1:0] sub_q, n_sub;
	logic             beat_q, n_beat;
	logic             need_div;

	logic [CW:0]      bc_inc, lc_inc;
	logic             bfire, lfire;
	logic [SUM_W-1:0] sum_add;
	logic [DIV_W-1:0] sub_sat;

	logic             div_busy, div_done;
	logic [CW-1:0]    quotient;

	always_comb begin
		// a zero period fires on every tick, which the >= compare gives for free
		bc_inc  = {1'b0, bcnt_q} + 1'b1;
		lc_inc  = {1'b0, lcnt_q} + 1'b1;
		bfire   = (bc_inc >= {1'b0, bper_q});
		lfire   = (lc_inc >= {1'b0, lper_q});
		sum_add = sum_q + {2'b00, bcnt_q};

		if (divisor == '0)
			sub_sat = DIV_W'(1);
		else if (divisor > MAX_DIV_SAT)
			sub_sat = MAX_DIV_SAT;
		else
			sub_sat = divisor;

		n_learn  = learn_q;
		n_tap    = tap_q;
		n_sum    = sum_q;
		n_bcnt   = bcnt_q;
		n_bper   = bper_q;
		n_lcnt   = lcnt_q;
		n_lrun   = lrun_q;
		n_led    = led_q;
		n_lper   = lper_q;
		n_sub    = sub_q;
		n_beat   = 1'b0;
		need_div = 1'b0;

		case (command)
			CMD_TICK: begin
				if (lrun_q) begin
					if (lfire) begin
						n_lcnt = '0;
						n_led  = ~led_q;
					end else begin
						n_lcnt = lc_inc[CW-1:0];
					end
				end
				if (bfire) begin
					n_bcnt = '0;
					n_beat = 1'b1;
					// learn timeout: reapply the old period
					if (learn_q) begin
						need_div = 1'b1;
						n_learn  = 1'b0;
						n_tap    = '0;
						n_lcnt   = '0;
						n_lrun   = 1'b1;
					end
				end else begin
					n_bcnt = bc_inc[CW-1:0];
				end
			end
			CMD_TAP: begin
				n_bcnt = '0;
				if (!learn_q) begin
					n_learn = 1'b1;
					n_tap   = '0;
					n_sum   = '0;
					n_lrun  = 1'b0;
					n_bper  = FULL;
				end else begin
					n_sum = sum_add;
					if (tap_q >= TAP_LAST) begin
						n_lper   = sum_add[SUM_W-1:2];
						need_div = 1'b1;
						n_lcnt   = '0;
						n_lrun   = 1'b1;
						n_tap    = '0;
						n_learn  = 1'b0;
					end else begin
						n_bper = FULL;
						n_tap  = tap_q + 1'b1;
					end
				end
			end
			CMD_SUBDIV: begin
				n_sub    = sub_sat;
				need_div = 1'b1;
				n_bcnt   = '0;
				n_lcnt   = '0;
				n_lrun   = 1'b1;
				n_beat   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q <= 1'b0;
			tap_q   <= '0;
			sum_q   <= '0;
			bcnt_q  <= '0;
			bper_q  <= FULL >> 4;
			lcnt_q  <= '0;
			lrun_q  <= 1'b0;
			led_q   <= 1'b0;
			lper_q  <= FULL;
			sub_q   <= DIV_W'(1);
			beat_q  <= 1'b0;
		end else begin
			if (ctrl.take) begin
				learn_q <= n_learn;
				tap_q   <= n_tap;
				sum_q   <= n_sum;
				bcnt_q  <= n_bcnt;
				lcnt_q  <= n_lcnt;
				lrun_q  <= n_lrun;
				led_q   <= n_led;
				lper_q  <= n_lper;
				sub_q   <= n_sub;
				beat_q  <= n_beat;
			end
			if (div_done)
				bper_q <= quotient;
			else if (ctrl.take)
				bper_q <= n_bper;
		end
	end

	ttb_divider #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_go),
		.dividend (n_lper),
		.divisor  (n_sub),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign stat.needs_div = need_div;
	assign stat.div_done  = div_done;
	assign stat.div_busy  = div_busy;

	assign beat         = beat_q;
	assign led_level    = led_q;
	assign learning     = learn_q;
	assign taps_taken   = tap_q;
	assign tempo_period = lper_q;

endmodule

// ----- sv/ttb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttb_ctrl
// Handshake controller: accepts a word when the result register is free
// and no division is running, and holds off input while the divider works.
// ----------------------------------------------------------------------------
module ttb_ctrl import ttb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  ttb_stat_t stat,
	output ttb_ctrl_t ctrl
);

	typedef enum logic {
		S_IDLE,
		S_DIV
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_ready);
		ctrl.take   = in_valid && in_ready;
		ctrl.div_go = ctrl.take && stat.needs_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.take)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (ctrl.div_go)
						state_q <= S_DIV;
				end
				S_DIV: begin
					if (stat.div_done)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- bench/tempo_checker.sv -----
// ----------------------------------------------------------------------------
// tempo_checker
// Watches both channels of the tap tempo beat generator, predicts every
// result word from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
module tempo_checker import ttb_pkg::*; #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned MAX_DIVISOR = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [DIV_W-1:0]       divisor,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic                   beat,
	input  logic                   led_level,
	input  logic                   learning,
	input  logic [TAP_W-1:0]       taps_taken,
	input  logic [COUNT_WIDTH-1:0] tempo_period,
	output int                     errors,
	output int                     pending,
	output int                     words_checked,
	output int                     beats_seen,
	output int                     periods_learned
);

	typedef struct packed {
		logic                   beat;
		logic                   led;
		logic                   learn;
		logic [TAP_W-1:0]       taps;
		logic [COUNT_WIDTH-1:0] period;
	} tempo_word_t;

	localparam logic [63:0] FULL     = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam logic [63:0] SUM_MASK = (64'd1 << (COUNT_WIDTH + 2)) - 64'd1;

	// predicted state of the generator
	logic             learn_on;
	logic [TAP_W-1:0] tap_idx;
	logic [63:0]      tap_sum;
	logic [63:0]      beat_cnt;
	logic [63:0]      beat_per;
	logic [63:0]      led_cnt;
	logic             led_on;
	logic             led_lvl;
	logic [63:0]      period;
	logic [DIV_W-1:0] subdiv;

	tempo_word_t expected_words[$];

	function automatic logic [63:0] at_least_one(input logic [63:0] p);
		return (p == 64'd0) ? 64'd1 : p;
	endfunction

	// new beat period from the learned period, both timers from zero
	function automatic void restart_timers();
		beat_per = period / {57'd0, subdiv};
		beat_cnt = 64'd0;
		led_cnt  = 64'd0;
		led_on   = 1'b1;
	endfunction

	function automatic tempo_word_t advance_tempo(input logic [1:0] cmd,
	                                              input logic [DIV_W-1:0] div);
		tempo_word_t      w;
		logic             fired;
		logic [DIV_W-1:0] d;
		fired = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (led_on) begin
					led_cnt++;
					if (led_cnt >= at_least_one(period)) begin
						led_cnt = 64'd0;
						led_lvl = ~led_lvl;
					end
				end
				beat_cnt++;
				if (beat_cnt >= at_least_one(beat_per)) begin
					beat_cnt = 64'd0;
					// beat timer ran out while learning: keep the old period
					if (learn_on) begin
						restart_timers();
						learn_on = 1'b0;
						tap_idx  = '0;
					end
					fired = 1'b1;
				end
			end
			CMD_TAP: begin
				if (!learn_on) begin
					learn_on = 1'b1;
					tap_idx  = '0;
					tap_sum  = 64'd0;
					led_on   = 1'b0;
					beat_per = FULL;
					beat_cnt = 64'd0;
				end else begin
					tap_sum  = (tap_sum + beat_cnt) & SUM_MASK;
					beat_cnt = 64'd0;
					if (tap_idx >= TAP_LAST) begin
						period = (tap_sum >> 2) & FULL;
						restart_timers();
						tap_idx  = '0;
						learn_on = 1'b0;
						periods_learned++;
					end else begin
						beat_per = FULL;
						tap_idx++;
					end
				end
			end
			CMD_SUBDIV: begin
				d = (div == '0) ? DIV_W'(1) : div;
				if (d > MAX_DIVISOR)
					d = DIV_W'(MAX_DIVISOR);
				subdiv = d;
				restart_timers();
				fired = 1'b1;
			end
			default: ;
		endcase
		w.beat   = fired;
		w.led    = led_lvl;
		w.learn  = learn_on;
		w.taps   = tap_idx;
		w.period = period[COUNT_WIDTH-1:0];
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tempo_word_t got;
		tempo_word_t want;
		if (!arst_n) begin
			learn_on        = 1'b0;
			tap_idx         = '0;
			tap_sum         = 64'd0;
			beat_cnt        = 64'd0;
			beat_per        = FULL >> 4;
			led_cnt         = 64'd0;
			led_on          = 1'b0;
			led_lvl         = 1'b0;
			period          = FULL;
			subdiv          = DIV_W'(1);
			errors          = 0;
			words_checked   = 0;
			beats_seen      = 0;
			periods_learned = 0;
			expected_words.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_words.push_back(advance_tempo(command, divisor));
			if (out_valid && out_ready) begin
				got = {beat, led_level, learning, taps_taken, tempo_period};
				if (expected_words.size() == 0) begin
					$error("result word with no word expected");
					errors++;
				end else begin
					want = expected_words.pop_front();
					if (got.beat !== want.beat) begin
						$error("beat: expected %0d, got %0d", want.beat, got.beat);
						errors++;
					end
					if (got.led !== want.led) begin
						$error("led_level: expected %0d, got %0d", want.led, got.led);
						errors++;
					end
					if (got.learn !== want.learn) begin
						$error("learning: expected %0d, got %0d", want.learn, got.learn);
						errors++;
					end
					if (got.taps !== want.taps) begin
						$error("taps_taken: expected %0d, got %0d", want.taps, got.taps);
						errors++;
					end
					if (got.period !== want.period) begin
						$error("tempo_period: expected %0d, got %0d",
							want.period, got.period);
						errors++;
					end
					words_checked++;
					if (want.beat)
						beats_seen++;
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ----- bench/tap_tempo_beat_generator_top_test.sv -----
// ----------------------------------------------------------------------------
// tap_tempo_beat_generator_top_test
// Drives ticks, taps and subdivision changes into the beat generator with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tap_tempo_beat_generator_top_test;
	import ttb_pkg::*;

	localparam int unsigned COUNT_WIDTH = 32;
	localparam int unsigned MAX_DIVISOR = 64;
	localparam logic [1:0]  CMD_NONE    = 2'd3;  // unused code, block ignores it
	localparam int          WORD_TARGET = 1100;
	localparam int          HOLD_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             command;
	logic [DIV_W-1:0]       divisor;
	logic                   out_valid;
	logic                   out_ready;
	logic                   beat;
	logic                   led_level;
	logic                   learning;
	logic [TAP_W-1:0]       taps_taken;
	logic [COUNT_WIDTH-1:0] tempo_period;

	int errors;
	int pending;
	int words_checked;
	int beats_seen;
	int periods_learned;

	int   words_sent = 0;
	int   hold_reqs  = 0;
	logic calm       = 1'b0;

	always #2 clk = ~clk;

	tap_tempo_beat_generator_top #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.MAX_DIVISOR(MAX_DIVISOR)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.beat(beat),
		.led_level(led_level),
		.learning(learning),
		.taps_taken(taps_taken),
		.tempo_period(tempo_period)
	);

	tempo_checker #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.MAX_DIVISOR(MAX_DIVISOR)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.beat(beat),
		.led_level(led_level),
		.learning(learning),
		.taps_taken(taps_taken),
		.tempo_period(tempo_period),
		.errors(errors),
		.pending(pending),
		.words_checked(words_checked),
		.beats_seen(beats_seen),
		.periods_learned(periods_learned)
	);

	// offer one word; returns at the edge where it is taken
	task automatic push_word(input logic [1:0] cmd, input logic [DIV_W-1:0] div);
		while (!calm && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		divisor  <= div;
		do
			@(posedge clk);
		while (!in_ready);
		if (cmd != CMD_NONE)
			words_sent++;
	endtask

	task automatic tick_run(input int n);
		repeat (n) push_word(CMD_TICK, DIV_W'($urandom_range(127)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// mostly small subdivisions, plus zero and out-of-range values
	function automatic logic [DIV_W-1:0] pick_divisor();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return DIV_W'($urandom_range(1, 8));
		else if (r < 75)
			return '0;
		else if (r < 87)
			return DIV_W'($urandom_range(65, 127));
		else
			return DIV_W'($urandom_range(9, 64));
	endfunction

	// first tap, four measured intervals, optional subdivision change inside
	task automatic learn_seq(input int gap_max, input bit mid_subdiv);
		int k;
		int hit;
		hit = $urandom_range(3);
		push_word(CMD_TAP, DIV_W'($urandom_range(127)));
		for (k = 0; k < 4; k++) begin
			tick_run($urandom_range(gap_max));
			if (mid_subdiv && k == hit)
				push_word(CMD_SUBDIV, pick_divisor());
			push_word(CMD_TAP, DIV_W'($urandom_range(127)));
		end
	endtask

	// output side: random stalls, calm stretch, one long hold-off on request
	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 37);
			end
		end
	end

	initial begin : timeout
		#4000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int  r;
		int  n;
		bit  held;
		bit  drained;
		held     = 1'b0;
		drained  = 1'b0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		command  <= CMD_TICK;
		divisor  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, unused code, divisor edges, zero period,
		// subdivision change during learning that ends it on the next tick
		push_word(CMD_TICK, 7'd0);
		push_word(CMD_NONE, 7'd127);
		push_word(CMD_TICK, 7'd127);
		push_word(CMD_SUBDIV, 7'd0);
		push_word(CMD_SUBDIV, 7'd127);
		push_word(CMD_SUBDIV, 7'd64);
		push_word(CMD_SUBDIV, 7'd1);
		repeat (5) push_word(CMD_TAP, 7'h55);
		repeat (2) push_word(CMD_TICK, 7'h2a);
		push_word(CMD_TAP, 7'd0);
		push_word(CMD_TICK, 7'd0);
		push_word(CMD_TAP, 7'd0);
		push_word(CMD_SUBDIV, 7'd2);
		push_word(CMD_TICK, 7'd0);
		push_word(CMD_TICK, 7'd0);
		push_word(CMD_TAP, 7'd0);
		push_word(CMD_TAP, 7'd0);
		drain();

		while (words_sent < WORD_TARGET) begin
			calm = (words_sent >= 450 && words_sent < 650);
			if (!held && words_sent > 250) begin
				// stall the output while ticks keep coming
				held = 1'b1;
				hold_reqs++;
				tick_run(80);
			end
			if ((!drained && words_sent > 750) || $urandom_range(99) < 4) begin
				drained = 1'b1;
				drain();
			end
			r = $urandom_range(99);
			if (r < 55) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(20, 40)
				                             : $urandom_range(1, 12);
				learn_seq(n, $urandom_range(9) == 0);
				tick_run($urandom_range(5, 60));
			end else if (r < 75) begin
				push_word(CMD_SUBDIV, pick_divisor());
				tick_run($urandom_range(1, 40));
			end else if (r < 85) begin
				// broken measurement: too few taps
				push_word(CMD_TAP, DIV_W'($urandom_range(127)));
				repeat ($urandom_range(2)) begin
					tick_run($urandom_range(6));
					push_word(CMD_TAP, DIV_W'($urandom_range(127)));
				end
				if ($urandom_range(1))
					push_word(CMD_SUBDIV, pick_divisor());
				tick_run($urandom_range(1, 30));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					n = $urandom_range(3);
					push_word(n[1:0], (n == CMD_SUBDIV) ? pick_divisor()
					                                  : DIV_W'($urandom_range(127)));
				end
			end
		end

		calm = 1'b0;
		drain();
		repeat (COUNT_WIDTH + 8) @(posedge clk);
		$display("Sent %0d words, checked %0d results with %0d beats.",
			words_sent, words_checked, beats_seen);
		$display("Learned %0d tap periods across divisors, noise and stalls.",
			periods_learned);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- tap_tempo_beat_generator_top.f -----
sv/ttb_pkg.sv
sv/ttb_divider.sv
sv/ttb_datapath.sv
sv/ttb_ctrl.sv
sv/tap_tempo_beat_generator_top.sv
bench/tempo_checker.sv
bench/tap_tempo_beat_generator_top_test.sv
